/* src/assert_macros.svh */
// Assertion macros shared by the positional list store modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PLS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Check that a condition holds in the same cycle as its trigger.
`define PLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/pls_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package pls_pkg;

   // Field widths of the transactions
   localparam int CMD_W       = 2;
   localparam int POS_W       = 6;
   localparam int WORD_W      = 64;
   localparam int LEN_W       = 6;
   localparam int STAT_W      = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;
   localparam int REQ_PAD_W   = REQ_TDATA_W - POS_W - WORD_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - WORD_W - LEN_W;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEF      = 32;
   localparam int DATA_WIDTH_DEF = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;    // take the request and its status
      logic idx_init;   // load the shift index
      logic shift_rd;   // read the neighbour of the index slot
      logic shift_wr;   // write the read word into the index slot, step index
      logic place;      // write the new word at its position
      logic get_rd;     // read the word at the requested position
      logic count_inc;
      logic count_dec;
      logic load_rsp;   // load the result register
   } pls_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [STAT_W-1:0] status;
      logic              shift_more;
   } pls_stat_type;

endpackage

/* src/pls_datapath.sv */
// Datapath: entry memory, list length, shift index and result register.
`include "assert_macros.svh"

module pls_datapath
   import pls_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CMD_W-1:0]       req_tuser,   // command
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // position, entry_data
   input  pls_cmd_type            cmd,
   output pls_stat_type           stat,
   output logic [STAT_W-1:0]      rsp_tuser,   // status
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // read_data, list_length
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CMD_W-1:0]      op_ff;
   logic [STAT_W-1:0]     status_ff;
   logic [STAT_W-1:0]     status_in;
   logic [AW-1:0]         pos_m1_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [AW-1:0]         idx_ff;
   logic [AW-1:0]         idx_in;
   logic [DATA_WIDTH-1:0] rdq_ff;
   logic [STAT_W-1:0]     rsp_status_ff;
   logic [WORD_W-1:0]     rsp_data_ff;
   logic [LEN_W-1:0]      rsp_len_ff;

   logic [CMPW-1:0]       req_pos_ext;
   logic [CMPW-1:0]       req_pos_m1;
   logic [CMPW-1:0]       cnt_ext;
   logic [CMPW-1:0]       idx_ext;
   logic                  is_full;
   logic                  is_empty;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  mem_re;
   logic                  mem_we;

   assign req_pos_ext = CMPW'(req_tdata[POS_W-1:0]);
   assign req_pos_m1  = req_pos_ext - CMPW'(1);
   assign cnt_ext     = CMPW'(count_ff);
   assign idx_ext     = CMPW'(idx_ff);
   assign is_full     = (count_ff == CW'(DEPTH));
   assign is_empty    = (count_ff == '0);

   // Decode the status of an incoming command against the current length
   always_comb begin
      status_in = ST_OK;
      unique case (req_tuser)
         CMD_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else if (req_pos_ext == '0 || req_pos_ext > cnt_ext + CMPW'(1)) begin
               status_in = ST_BADPOS;
            end
         end
         CMD_DELETE, CMD_READ: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else if (req_pos_ext == '0 || req_pos_ext > cnt_ext) begin
               status_in = ST_BADPOS;
            end
         end
         default: status_in = ST_BADPOS;
      endcase
   end

   // Hold the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_tuser;
         status_ff <= status_in;
         pos_m1_ff <= req_pos_m1[AW-1:0];
         data_ff   <= req_tdata[POS_W +: DATA_WIDTH];
      end
   end

   // Report status and whether shifting is still needed
   always_comb begin
      stat.op     = op_ff;
      stat.status = status_ff;
      if (op_ff == CMD_INSERT) begin
         stat.shift_more = (idx_ff != pos_m1_ff);
      end else begin
         stat.shift_more = (idx_ext + CMPW'(1) < cnt_ext);
      end
   end

   // Advance the shift index: inserts walk down, deletes walk up
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         idx_in = (op_ff == CMD_INSERT) ? cnt_ext[AW-1:0] : pos_m1_ff;
      end else if (cmd.shift_wr) begin
         idx_in = (op_ff == CMD_INSERT) ? idx_ff - AW'(1) : idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Track the list length
   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Select memory addresses and write data
   always_comb begin
      mem_re  = cmd.shift_rd | cmd.get_rd;
      mem_we  = cmd.shift_wr | cmd.place;
      rd_addr = pos_m1_ff;
      if (cmd.shift_rd) begin
         rd_addr = (op_ff == CMD_INSERT) ? idx_ff - AW'(1) : idx_ff + AW'(1);
      end
      wr_addr = cmd.place ? pos_m1_ff : idx_ff;
      wr_data = cmd.place ? data_ff : rdq_ff;
   end

   // Entry memory with one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdq_ff <= mem[rd_addr];
      end
   end

   // Load the result transaction
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_len_ff    <= cnt_ext[LEN_W-1:0];
         if (op_ff == CMD_READ && status_ff == ST_OK) begin
            rsp_data_ff <= WORD_W'(rdq_ff);
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_len_ff, rsp_data_ff};

   `PLS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH),
      "list length exceeds depth")
   `PLS_ASSERT_IMPLY(a_shift_in_range, clock, reset, cmd.shift_wr, idx_ext <= cnt_ext,
      "shift writes beyond the list")

endmodule

/* src/pls_ctrl.sv */
// Controller: sequences capture, shifting, placement and result hand-off.
`include "assert_macros.svh"

module pls_ctrl
   import pls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  pls_stat_type stat,
   output pls_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_DISPATCH   = 3'd1;
   localparam logic [2:0] S_SHIFT_TEST = 3'd2;
   localparam logic [2:0] S_SHIFT_WR   = 3'd3;
   localparam logic [2:0] S_FINISH     = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.status != ST_OK) begin
               state_in = S_FINISH;
            end else if (stat.op == CMD_READ) begin
               cmd.get_rd = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.idx_init = 1'b1;
               state_in     = S_SHIFT_TEST;
            end
         end
         S_SHIFT_TEST: begin
            if (stat.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end else if (stat.op == CMD_INSERT) begin
               cmd.place     = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_TEST;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result valid until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PLS_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.load_rsp,
      !rsp_valid_ff || rsp_tready, "result overwritten before it was taken")
   `PLS_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_tvalid && req_tready,
      state_ff == S_DISPATCH, "accepted transaction not dispatched")

endmodule

/* src/positional_list_store.sv */
// Top level of the positional list store: controller plus datapath.
//
// Ordered list of up to DEPTH words addressed by 1-based position.
// Request channel (req_): tuser carries the command (insert, delete, read),
// tdata the position and the word to insert. Result channel (rsp_): tuser
// carries the status (ok, full, empty, bad position), tdata the read word
// (zero unless a read succeeded) and the list length after the command.
// Every request gives exactly one result, in order.
// Sequence: a request is captured in the idle state and checked in the
// dispatch state. A read or any rejected command then goes to the finish
// state, which loads the result register; the next request is taken only
// after that. An insert at position p into a list of n entries moves n-p+1
// words, a delete moves n-p words; each move is a registered read of the
// neighbour, then a write; the length update and result load follow.
// Reset clears the length and the handshake state; the memory is not
// cleared, as only written entries can ever be read. A stalled receiver
// holds the result register; the next request is still accepted and
// processed, and its result waits until the register frees.
module positional_list_store
   import pls_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CMD_W-1:0]       req_tuser,   // [1:0] command
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [5:0] position, [69:6] entry_data
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [STAT_W-1:0]      rsp_tuser,   // [1:0] status
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [63:0] read_data, [69:64] list_length
);

   pls_cmd_type  cmd;
   pls_stat_type stat;

   pls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pls_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule
